@@ design/sha_pkg.sv @@
// sha-256 package: round constants, initial hash values, round functions
// no dependencies
`default_nettype none
package sha_pkg;

  localparam int unsigned RoundCount = 64;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } sha_item_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    begin
      case (i)
        6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
        6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
        6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
        6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
        6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
        6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
        6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
        6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
        6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
        6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
        6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
        6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
        6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
        6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
        6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
        6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
        6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
        6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
        6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
        6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
        6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
        default: k = 32'hc67178f2;
      endcase
      return k;
    end
  endfunction

  function automatic logic [31:0] initial_h(input logic [2:0] i);
    logic [31:0] h;
    begin
      case (i)
        3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
        3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
        3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
        3'd6: h = 32'h1f83d9ab;
        default: h = 32'h5be0cd19;
      endcase
      return h;
    end
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

@@ design/sha_in_queue.sv @@
// front part: short item queue between the input channel and the core
// depends on sha_pkg
`default_nettype none
module sha_in_queue
  import sha_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire sha_item_t push_item,
  output logic           full,
  input  wire logic      pop,
  output sha_item_t      pop_item,
  output logic           empty
);
  localparam int unsigned AW = $clog2(QueueDepth);
  sha_item_t       mem [QueueDepth];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     count;
  logic            do_push;
  logic            do_pop;

  assign full     = (count == (AW+1)'(QueueDepth));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end
endmodule
`default_nettype wire

@@ design/sha_core.sv @@
// back part: block buffer, padding sequencer, one-round-per-cycle compression
// and digest output register; depends on sha_pkg
`default_nettype none
module sha_core
  import sha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  input  wire sha_item_t   item,
  output logic             item_take,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last,
  output logic             empty,
  input  wire logic        pop
);
  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_LOAD, S_ROUND, S_FOLD, S_EMIT
  } state_t;

  state_t       state;
  logic [31:0]  buf_mem [BlockBytes/4];
  logic [5:0]   fill;
  logic [63:0]  bit_count;
  logic [31:0]  hv [8];
  logic [31:0]  w [16];
  logic [31:0]  a, b, c, d, e, f, g, h;
  logic [5:0]   rnd;
  logic [5:0]   pad_idx;
  logic         finishing;
  logic         len_block;
  logic [3:0]   load_idx;
  logic [2:0]   out_idx;
  logic         out_valid;

  logic [31:0]  t1, t2, w_new, s0, s1;
  logic [7:0]   pad_byte;

  assign item_take = (state == S_IDLE) && item_valid;

  always_comb begin
    s0    = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1    = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    w_new = s1 + w[9] + s0 + w[0];
    t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + round_k(rnd) + w[0];
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
    if (pad_idx >= 6'd56 && !len_block) begin
      pad_byte = 8'h00;
    end else if (pad_idx >= 6'd56) begin
      pad_byte = bit_count[8'd63 - {2'b00, pad_idx[2:0], 3'b000} -: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // block buffer holds big-endian words, byte 0 of a word in the top lane
  always_ff @(posedge clk) begin
    if (state == S_IDLE && item_valid && !item.kind) begin
      buf_mem[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= item.data_byte;
    end else if (state == S_IDLE && item_valid) begin
      buf_mem[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= 8'h80;
    end else if (state == S_PAD) begin
      buf_mem[pad_idx[5:2]][{~pad_idx[1:0], 3'b000} +: 8] <= pad_byte;
    end
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      bit_count <= '0;
      finishing <= 1'b0;
      len_block <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < 8; i++) hv[i] <= initial_h(3'(i));
    end else begin
      case (state)
        S_IDLE: begin
          if (item_valid && !item.kind) begin
            fill <= fill + 6'd1;
            if (fill == 6'd63) begin
              finishing <= 1'b0;
              load_idx  <= '0;
              state     <= S_LOAD;
            end
          end else if (item_valid) begin
            finishing <= 1'b1;
            bit_count <= bit_count + {55'd0, fill, 3'b000};
            len_block <= (fill < 6'd56);
            pad_idx   <= fill + 6'd1;
            state     <= (fill == 6'd63) ? S_LOAD : S_PAD;
            load_idx  <= '0;
          end
        end
        S_PAD: begin
          pad_idx <= pad_idx + 6'd1;
          if (pad_idx == 6'd63) begin
            load_idx <= '0;
            state    <= S_LOAD;
          end
        end
        S_LOAD: begin
          w[load_idx] <= buf_mem[load_idx];
          load_idx    <= load_idx + 4'd1;
          if (load_idx == 4'd15) begin
            a <= hv[0]; b <= hv[1]; c <= hv[2]; d <= hv[3];
            e <= hv[4]; f <= hv[5]; g <= hv[6]; h <= hv[7];
            rnd   <= '0;
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= w_new;
          h <= g; g <= f; f <= e; e <= d + t1;
          d <= c; c <= b; b <= a; a <= t1 + t2;
          rnd <= rnd + 6'd1;
          if (rnd == 6'(RoundCount - 1)) state <= S_FOLD;
        end
        S_FOLD: begin
          hv[0] <= hv[0] + a; hv[1] <= hv[1] + b;
          hv[2] <= hv[2] + c; hv[3] <= hv[3] + d;
          hv[4] <= hv[4] + e; hv[5] <= hv[5] + f;
          hv[6] <= hv[6] + g; hv[7] <= hv[7] + h;
          if (!finishing) begin
            bit_count <= bit_count + 64'd512;
            fill      <= '0;
            state     <= S_IDLE;
          end else if (!len_block) begin
            len_block <= 1'b1;
            pad_idx   <= '0;
            state     <= S_PAD;
          end else begin
            out_idx   <= '0;
            out_valid <= 1'b1;
            state     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (pop) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              out_valid <= 1'b0;
              fill      <= '0;
              bit_count <= '0;
              finishing <= 1'b0;
              for (int i = 0; i < 8; i++) hv[i] <= initial_h(3'(i));
              state     <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign empty       = !out_valid;
  assign digest_word = hv[out_idx];
  assign word_index  = out_idx;
  assign last        = (out_idx == 3'd7);
endmodule
`default_nettype wire

@@ design/sha256_byte_stream_hasher.sv @@
// sha-256 over a byte stream: top level joining the item queue and the core
// depends on sha_pkg, sha_in_queue, sha_core
//
// input channel: push/full carry kind and data_byte. kind 0 adds one message
// byte; kind 1 pads the message, hashes it and yields eight digest words.
// output channel: empty/pop carry digest_word, word_index and last; the
// oldest word sits on the ports while empty is low.
// a four-entry queue takes items while the core works. a data byte goes into
// the block buffer; the 64th byte of a block adds a load of sixteen words, 64
// rounds and a fold (one round per cycle in the core). a finish item writes
// the 0x80 byte, then for each of one or two final blocks a padding sweep and
// a compression follow, then eight output transactions.
// while the receiver holds pop low the core waits on the digest and the
// queue fills, then full rises. synchronous rst returns the hash state to
// the initial values and empties the queue and the output.
`default_nettype none
module sha256_byte_stream_hasher
  import sha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic        kind,
  input  wire logic [7:0]  data_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last
);
  sha_item_t in_item;
  sha_item_t q_item;
  logic      q_empty;
  logic      take;

  assign in_item.kind      = kind;
  assign in_item.data_byte = data_byte;

  sha_in_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_item(in_item), .full(full),
    .pop(take), .pop_item(q_item), .empty(q_empty)
  );

  sha_core u_core (
    .clk(clk), .rst(rst), .item_valid(!q_empty), .item(q_item),
    .item_take(take), .digest_word(digest_word), .word_index(word_index),
    .last(last), .empty(empty), .pop(pop)
  );

  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (last == (word_index == 3'd7)))
    else $error("last flag out of step with word index");
  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !last) |=> (!empty && word_index == $past(word_index) + 3'd1))
    else $error("digest word index did not advance");
  a_take_q: assert property (@(posedge clk) disable iff (rst)
    take |-> !q_empty)
    else $error("core took from empty queue");
endmodule
`default_nettype wire

@@ sim/sha256_byte_stream_hasher_test.sv @@
// testbench for sha256_byte_stream_hasher: byte stream in, digest words out
// depends on sha_pkg and the hasher rtl; predicts digests with its own sha-256
`default_nettype none
module sha256_byte_stream_hasher_test
  import sha_pkg::*;
();

  typedef enum logic {KIND_DATA = 1'b0, KIND_FINISH = 1'b1} item_kind_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned DrainCycles = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic kind = 1'b0;
  logic [7:0] data_byte = 8'h00;
  logic pop = 1'b0;
  logic full, empty, last;
  logic [31:0] digest_word;
  logic [2:0] word_index;

  sha256_byte_stream_hasher i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .kind(kind),
    .data_byte(data_byte), .empty(empty), .pop(pop),
    .digest_word(digest_word), .word_index(word_index), .last(last)
  );

  always #10 clk = ~clk;

  logic [8:0] pending_items[$];
  logic [8:0] hold_marks[$];
  digest_word_t expected_words[$];
  logic [31:0] hash_state[8];
  logic [7:0] block_bytes[64];
  int unsigned block_fill;
  logic [63:0] bit_count;
  int error_count = 0;
  int unsigned idle_cycles = 0;
  bit stimulus_done = 1'b0;
  bit item_taken = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned items_sent = 0;
  int unsigned hold_at = 0;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic compress_block();
    logic [31:0] w[64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    {a, b, c, d, e, f, g, h} = {hash_state[0], hash_state[1], hash_state[2], hash_state[3],
                                hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) + round_k(i[5:0])
           + w[i];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endtask

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) hash_state[i] = initial_h(i[2:0]);
    block_fill = 0;
    bit_count = '0;
  endtask

  task automatic predict_item(input logic [8:0] item);
    digest_word_t dw;
    if (item[8] == KIND_DATA) begin
      block_bytes[block_fill] = item[7:0];
      block_fill++;
      if (block_fill == 64) begin
        compress_block();
        bit_count += 64'd512;
        block_fill = 0;
      end
    end else begin
      block_bytes[block_fill] = 8'h80;
      for (int i = block_fill + 1; i < 64; i++) block_bytes[i] = 8'h00;
      if (block_fill >= 56) begin
        compress_block();
        for (int i = 0; i < 56; i++) block_bytes[i] = 8'h00;
      end
      bit_count += 64'(block_fill) * 64'd8;
      for (int i = 0; i < 8; i++) block_bytes[56+i] = bit_count[63-8*i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
        dw.word = hash_state[i];
        dw.index = i[2:0];
        dw.last = (i == 7);
        expected_words.push_back(dw);
      end
      restart_hash();
    end
  endtask

  task automatic add_message(input int unsigned len, input bit with_finish);
    for (int i = 0; i < len; i++) pending_items.push_back({KIND_DATA, 8'($urandom)});
    if (with_finish) pending_items.push_back({KIND_FINISH, 8'($urandom)});
  endtask

  initial begin
    restart_hash();
    // directed: empty message, data byte extremes, two final blocks, full block
    pending_items.push_back({KIND_FINISH, 8'hff});
    pending_items.push_back({KIND_DATA, 8'h00});
    pending_items.push_back({KIND_DATA, 8'hff});
    pending_items.push_back({KIND_FINISH, 8'h00});
    add_message(63, 1'b1);
    add_message(64, 1'b1);
    hold_at = pending_items.size();
    while (pending_items.size() < hold_at + 24) begin
      case ($urandom_range(0, 9))
        0: pending_items.push_back({KIND_FINISH, 8'($urandom)});
        1: add_message($urandom_range(20, 30), 1'b1);
        default: add_message($urandom_range(0, 12), 1'b1);
      endcase
    end
    repeat (3) @(posedge clk);
    @(negedge clk) rst = 1'b0;
  end

  always @(posedge clk) begin
    logic accepted;
    accepted = 1'b0;
    item_taken = !rst && push && !full;
    if (!rst) begin
      if (push && !full) begin
        predict_item({kind, data_byte});
        items_sent++;
        accepted = 1'b1;
      end
      if (pop && !empty) begin
        accepted = 1'b1;
        if (expected_words.size() == 0) begin
          $error("digest word with nothing expected: %h", digest_word);
          error_count++;
        end else begin
          digest_word_t exp_w;
          exp_w = expected_words.pop_front();
          if (digest_word !== exp_w.word) begin
            $error("digest_word expected %h actual %h", exp_w.word, digest_word);
            error_count++;
          end
          if (word_index !== exp_w.index) begin
            $error("word_index expected %0d actual %0d", exp_w.index, word_index);
            error_count++;
          end
          if (last !== exp_w.last) begin
            $error("last expected %0d actual %0d", exp_w.last, last);
            error_count++;
          end
        end
      end
      idle_cycles = accepted ? 0 : idle_cycles + 1;
      if (idle_cycles >= IdleLimit && !stimulus_done) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // driver
  always @(negedge clk) begin
    logic [8:0] next_item;
    if (rst) begin
      push <= 1'b0;
    end else if (push && !item_taken) begin
      push <= 1'b1;
    end else if (items_sent == hold_at && hold_at != 0 && expected_words.size() != 0) begin
      push <= 1'b0;
    end else if (send_gap != 0) begin
      send_gap--;
      push <= 1'b0;
    end else if (pending_items.size() != 0) begin
      next_item = pending_items.pop_front();
      push <= 1'b1;
      kind <= next_item[8];
      data_byte <= next_item[7:0];
      send_gap = pick_gap();
      if (items_sent + 1 == hold_at) hold_at = items_sent + 1;
    end else begin
      push <= 1'b0;
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (recv_gap != 0) begin
      recv_gap--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
      if ($urandom_range(0, 3) == 0) recv_gap = pick_gap();
    end
  end

  initial begin
    @(negedge rst);
    while (pending_items.size() != 0 || push) @(posedge clk);
    stimulus_done = 1'b1;
    fork
      begin
        while (expected_words.size() != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
      end
      begin
        repeat (200000) @(posedge clk);
        error_count++;
      end
    join_any
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
